// ===== hw/rtl/bmsd_pkg.sv =====
`default_nettype none

package bmsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LENGTH_BITS = 16;

  localparam int SUM_W  = SAMPLE_BITS + LENGTH_BITS + 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS + LENGTH_BITS - 1;
  localparam int LEN_W  = LENGTH_BITS + 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;

  // radicand padded to an even width, two bits consumed per root step
  localparam int VAR_W  = SQ_W + (SQ_W % 2);
  localparam int ROOT_W = VAR_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  localparam int DIV_STEPS  = SQ_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(1) << LENGTH_BITS;
  localparam logic [SAMPLE_BITS-1:0] POS_LIMIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] NEG_LIMIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sqsum;
    logic [LEN_W-1:0] len;
  } blk_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQR,
    ST_VAR,
    ST_ROOT,
    ST_FIN
  } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/block_mean_and_std_deviation_top.sv =====
// channel   handshake               payload
// cfg       cfg_valid / cfg_ready    cfg_data[16:0] (block length)
// in        in_valid / in_ready      sample[15:0] signed Q8.8
// out       out_valid / out_ready    mean_value[15:0] signed, std_deviation[15:0]
//
// One sample beat per cycle while the two-entry block queue has room.
// Each closed block passes through the back end as a pop, 47 shared divide steps,
// square, variance, 24 root steps and a final load into the output register.
// rst (synchronous) clears accumulators, queue and back end; length resets to 65536.
// A held output beat stalls the back end; a full queue stalls sample beats.
`default_nettype none

module block_mean_and_std_deviation_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bmsd_pkg::LEN_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [bmsd_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bmsd_pkg::SAMPLE_BITS-1:0] mean_value,
  output logic [bmsd_pkg::SAMPLE_BITS-1:0]       std_deviation
);
  import bmsd_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  blk_t q_in;
  blk_t q_head;

  bmsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  bmsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  bmsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mean_value    (mean_value),
    .std_deviation (std_deviation)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bmsd_front.sv =====
`default_nettype none

module bmsd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bmsd_pkg::LEN_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [bmsd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                               q_full,
  output logic                               q_push,
  output bmsd_pkg::blk_t                     q_data
);
  import bmsd_pkg::*;

  logic [LEN_W-1:0]             len;
  logic [LEN_W-1:0]             len_next;
  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             sum_next;
  logic [SQ_W-1:0]              sqsum;
  logic [SQ_W-1:0]              sqsum_next;
  logic [LEN_W-1:0]             count;
  logic [LEN_W-1:0]             count_next;
  logic signed [PROD_W-1:0]     sq;
  logic                         accept;
  logic                         close;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    len_next = cfg_data;
    if (cfg_data == '0) begin
      len_next = LEN_W'(1);
    end else if (cfg_data > MAX_LEN) begin
      len_next = MAX_LEN;
    end
  end

  assign sq         = sample * sample;
  assign sum_next   = sum + {{(SUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
  assign sqsum_next = sqsum + {{(SQ_W-PROD_W){1'b0}}, sq};
  assign count_next = count + LEN_W'(1);
  assign close      = count_next >= len;

  assign q_push       = accept && close;
  assign q_data.sum   = sum_next;
  assign q_data.sqsum = sqsum_next;
  assign q_data.len   = len;

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= MAX_LEN;
      sum   <= '0;
      sqsum <= '0;
      count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len <= len_next;
      end
      if (accept) begin
        if (close) begin
          sum   <= '0;
          sqsum <= '0;
          count <= '0;
        end else begin
          sum   <= sum_next;
          sqsum <= sqsum_next;
          count <= count_next;
        end
      end
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (count == '0) && (sum == '0) && (sqsum == '0))
    else $error("accumulators not cleared after block close");

endmodule

`default_nettype wire

// ===== hw/rtl/bmsd_queue.sv =====
`default_nettype none

module bmsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bmsd_pkg::blk_t push_data,
  output logic           full,
  input  logic           pop,
  output bmsd_pkg::blk_t head,
  output logic           empty
);
  import bmsd_pkg::*;

  blk_t               mem [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign full  = fill == QCNT_W'(Q_DEPTH);
  assign empty = fill == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/bmsd_back.sv =====
`default_nettype none

module bmsd_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_empty,
  input  bmsd_pkg::blk_t                         q_head,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bmsd_pkg::SAMPLE_BITS-1:0] mean_value,
  output logic [bmsd_pkg::SAMPLE_BITS-1:0]       std_deviation
);
  import bmsd_pkg::*;

  back_state_t               state;
  back_state_t               state_next;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          cnt_next;
  logic                      load_out;

  logic                      neg;
  logic [LEN_W-1:0]          len_q;
  logic [SQ_W-1:0]           dvd_a;
  logic [SQ_W-1:0]           dvd_b;
  logic [LEN_W-1:0]          rem_a;
  logic [LEN_W-1:0]          rem_b;
  logic [LEN_W:0]            part_a;
  logic [LEN_W:0]            part_b;
  logic                      ge_a;
  logic                      ge_b;
  logic [SUM_W-1:0]          mag;

  logic [SAMPLE_BITS-1:0]    qc;
  logic [SAMPLE_BITS-1:0]    mean_r;
  logic [PROD_W-1:0]         msq;
  logic [SQ_W-1:0]           msq_ext;

  logic [VAR_W-1:0]          rad;
  logic [REM_W-1:0]          rrem;
  logic [ROOT_W-1:0]         root;
  logic [REM_W+1:0]          r_try;
  logic [REM_W+1:0]          r_trial;
  logic                      r_ge;
  logic [SAMPLE_BITS-1:0]    sd;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_DIV;
      ST_DIV:  if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_SQR;
      ST_SQR:  state_next = ST_VAR;
      ST_VAR:  state_next = ST_ROOT;
      ST_ROOT: if (cnt == CNT_W'(ROOT_STEPS - 1)) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    cnt_next = '0;
    unique case (state)
      ST_IDLE: q_pop = !q_empty;
      ST_DIV:  cnt_next = (cnt == CNT_W'(DIV_STEPS - 1)) ? '0 : cnt + CNT_W'(1);
      ST_ROOT: cnt_next = (cnt == CNT_W'(ROOT_STEPS - 1)) ? '0 : cnt + CNT_W'(1);
      ST_FIN:  load_out = !out_valid || out_ready;
      default: cnt_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // two restoring-divide lanes: |sum| / len and sqsum / len
  assign mag    = q_head.sum[SUM_W-1] ? -q_head.sum : q_head.sum;
  assign part_a = {rem_a, dvd_a[SQ_W-1]};
  assign part_b = {rem_b, dvd_b[SQ_W-1]};
  assign ge_a   = part_a >= {1'b0, len_q};
  assign ge_b   = part_b >= {1'b0, len_q};

  always_comb begin
    qc = dvd_a[SAMPLE_BITS-1:0];
    if (neg) begin
      if (dvd_a > SQ_W'(NEG_LIMIT)) qc = NEG_LIMIT;
    end else begin
      if (dvd_a > SQ_W'(POS_LIMIT)) qc = POS_LIMIT;
    end
  end

  assign msq_ext = {{(SQ_W-PROD_W){1'b0}}, msq};

  // digit-by-digit square root, two radicand bits per step
  assign r_try   = {rrem, rad[VAR_W-1 -: 2]};
  assign r_trial = {2'b00, root, 2'b01};
  assign r_ge    = r_try >= r_trial;
  assign sd      = (|root[ROOT_W-1:SAMPLE_BITS]) ? '1 : root[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          neg   <= q_head.sum[SUM_W-1];
          len_q <= q_head.len;
          dvd_a <= {{(SQ_W-SUM_W){1'b0}}, mag};
          dvd_b <= q_head.sqsum;
          rem_a <= '0;
          rem_b <= '0;
        end
      end
      ST_DIV: begin
        rem_a <= ge_a ? LEN_W'(part_a - {1'b0, len_q}) : part_a[LEN_W-1:0];
        rem_b <= ge_b ? LEN_W'(part_b - {1'b0, len_q}) : part_b[LEN_W-1:0];
        dvd_a <= {dvd_a[SQ_W-2:0], ge_a};
        dvd_b <= {dvd_b[SQ_W-2:0], ge_b};
      end
      ST_SQR: begin
        msq    <= qc * qc;
        mean_r <= neg ? -qc : qc;
      end
      ST_VAR: begin
        rad  <= (dvd_b > msq_ext) ? VAR_W'(dvd_b - msq_ext) : '0;
        rrem <= '0;
        root <= '0;
      end
      ST_ROOT: begin
        rrem <= r_ge ? REM_W'(r_try - r_trial) : REM_W'(r_try);
        root <= {root[ROOT_W-2:0], r_ge};
        rad  <= {rad[VAR_W-3:0], 2'b00};
      end
      default: begin
        if (load_out) begin
          mean_value    <= mean_r;
          std_deviation <= sd;
        end
      end
    endcase
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem_a < len_q) && (rem_b < len_q))
    else $error("divider remainder out of range");
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_DIV) && (cnt == '0))
    else $error("block pop did not start divide");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (state == ST_FIN) && (cnt == '0))
    else $error("result loaded outside final state");

endmodule

`default_nettype wire

// ===== verif/block_mean_and_std_deviation_top_test.sv =====
`timescale 1ns / 100ps

module block_mean_and_std_deviation_top_test;
  import bmsd_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] sd;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] mean_value;
  logic [SAMPLE_BITS-1:0] std_deviation;

  logic no_gaps = 1'b0;
  int cycle_count = 0;
  int err_count = 0;
  int samples_sent = 0;
  int blocks_checked = 0;

  logic signed [SAMPLE_BITS-1:0] pending_samples[$];
  stats_t expected_stats[$];

  // running state of the statistics predictor
  logic [LEN_W-1:0] blk_len = MAX_LEN;
  logic [SUM_W-1:0] acc_sum = '0;
  logic [SQ_W-1:0] acc_sq = '0;
  logic [LEN_W-1:0] seen_cnt = '0;

  block_mean_and_std_deviation_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mean_value    (mean_value),
    .std_deviation (std_deviation)
  );

  always #4 clk = ~clk;

  function automatic bit take_break();
    return !no_gaps && ($urandom_range(99) < 6);
  endfunction

  function automatic logic [LEN_W-1:0] length_taken(input logic [LEN_W-1:0] w);
    if (w == '0) return LEN_W'(1);
    if (w > MAX_LEN) return MAX_LEN;
    return w;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return 64'(r);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return POS_LIMIT;
    if (roll == 1) return NEG_LIMIT;
    if (roll == 2) return '0;
    if (roll < 6) return SAMPLE_BITS'($urandom_range(1023)) - SAMPLE_BITS'(512);
    return SAMPLE_BITS'($urandom);
  endfunction

  task automatic fold_sample(input logic signed [SAMPLE_BITS-1:0] s);
    stats_t res;
    longint sl;
    logic neg;
    logic [SUM_W-1:0] sum_mag;
    logic [63:0] q;
    logic [63:0] ms;
    logic [63:0] spread;
    logic [63:0] root;
    sl = s;
    acc_sum = acc_sum + {{(SUM_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    acc_sq = acc_sq + SQ_W'(sl * sl);
    seen_cnt = seen_cnt + 1'b1;
    if (seen_cnt >= blk_len) begin
      neg = acc_sum[SUM_W-1];
      sum_mag = neg ? (SUM_W'(0) - acc_sum) : acc_sum;
      q = 64'(sum_mag) / 64'(blk_len);
      if (neg) begin
        if (q > 64'(NEG_LIMIT)) q = 64'(NEG_LIMIT);
        res.mean = SAMPLE_BITS'(64'd0 - q);
      end else begin
        if (q > 64'(POS_LIMIT)) q = 64'(POS_LIMIT);
        res.mean = SAMPLE_BITS'(q);
      end
      ms = 64'(acc_sq) / 64'(blk_len);
      spread = (ms > q * q) ? (ms - q * q) : 64'd0;
      root = floor_root(spread);
      res.sd = (root > 64'hFFFF) ? 16'hFFFF : SAMPLE_BITS'(root);
      expected_stats.push_back(res);
      acc_sum = '0;
      acc_sq = '0;
      seen_cnt = '0;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fold_sample(sample);
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && !take_break()) begin
          sample <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    stats_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          $error("unexpected result beat: mean_value %0d std_deviation %0d",
                 mean_value, std_deviation);
          err_count++;
        end else begin
          due = expected_stats.pop_front();
          blocks_checked++;
          if (mean_value !== due.mean) begin
            $error("mean_value: expected %0d, got %0d", $signed(due.mean), mean_value);
            err_count++;
          end
          if (std_deviation !== due.sd) begin
            $error("std_deviation: expected %0d, got %0d", due.sd, std_deviation);
            err_count++;
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    blk_len = length_taken(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_repeat(input logic signed [SAMPLE_BITS-1:0] v, input int n);
    repeat (n) pending_samples.push_back(v);
  endtask

  initial begin
    logic [LEN_W-1:0] len_w;
    logic [LEN_W-1:0] eff;
    int roll;
    int count;
    int random_sent;
    random_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset length holds the block open; a lower length then closes it
    queue_repeat(NEG_LIMIT, 40);
    settle();
    write_length(LEN_W'(8));
    pending_samples.push_back(NEG_LIMIT);
    settle();

    // zero length taken as one
    write_length('0);
    pending_samples.push_back(POS_LIMIT);
    pending_samples.push_back(NEG_LIMIT);
    pending_samples.push_back('0);
    pending_samples.push_back(-16'sd1);
    settle();
    write_length(LEN_W'(2));
    pending_samples.push_back(POS_LIMIT);
    pending_samples.push_back(NEG_LIMIT);
    settle();

    // length lowered mid-block: variance clamps to zero
    write_length(LEN_W'(4));
    queue_repeat(16'sd200, 3);
    settle();
    write_length(LEN_W'(2));
    pending_samples.push_back(16'sd200);
    settle();

    // length lowered mid-block: mean saturates
    write_length(LEN_W'(4));
    queue_repeat(POS_LIMIT, 3);
    settle();
    write_length(LEN_W'(1));
    pending_samples.push_back(POS_LIMIT);
    settle();

    // length lowered mid-block: deviation saturates
    write_length(LEN_W'(8));
    for (int i = 0; i < 7; i++) pending_samples.push_back((i % 2) ? NEG_LIMIT : POS_LIMIT);
    settle();
    write_length(LEN_W'(1));
    pending_samples.push_back(POS_LIMIT);
    settle();

    while (random_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 5) len_w = '0;
      else if (roll < 50) len_w = LEN_W'($urandom_range(8, 1));
      else if (roll < 80) len_w = LEN_W'($urandom_range(64, 9));
      else len_w = LEN_W'($urandom_range(400, 65));
      eff = length_taken(len_w);
      count = int'(eff) * ((eff <= 64) ? $urandom_range(3, 1) : 1)
              + $urandom_range(int'(eff) - 1, 0);
      if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
      no_gaps <= (random_sent >= 500 && random_sent < 1000);
      write_length(len_w);
      repeat (count) pending_samples.push_back(pick_sample());
      settle();
      random_sent += count;
    end
    no_gaps <= 1'b0;

    // over-range length taken as the maximum, then closed by a lower length
    write_length({LEN_W{1'b1}});
    repeat (70) pending_samples.push_back(pick_sample());
    settle();
    write_length(LEN_W'(64));
    pending_samples.push_back(pick_sample());
    settle();

    $display("%0d samples sent, %0d result beats checked", samples_sent, blocks_checked);
    $display("lengths 1 to 400, reset, zero and over-range lengths, mid-block changes");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
